>>> design/nfb_pkg.sv
// Shared types, codes and constants for the packed 4-bit framebuffer block.
`default_nettype none

package nfb_pkg;

  // Default store geometry.
  localparam int STORE_ROWS_DEF          = 128;
  localparam int STORE_BYTES_PER_ROW_DEF = 64;

  // Fixed widths of the command fields and of the walk counters.
  localparam int FUNC_W = 3;
  localparam int POS_W  = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 8;
  localparam int DATA_W = 8;
  localparam int GREY_W = 4;

  // Configuration port geometry.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes.
  localparam logic [1:0] REG_DISP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_DISP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GREY_LEVEL  = 2'd2;

  // Register reset values.
  localparam logic [POS_W-1:0]  DISP_WIDTH_RST  = 8'd128;
  localparam logic [POS_W-1:0]  DISP_HEIGHT_RST = 8'd96;
  localparam logic [GREY_W-1:0] GREY_LEVEL_RST  = 4'd15;

  // Command codes.
  localparam logic [FUNC_W-1:0] FN_SET     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CLR     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INV     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_BMP     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLR_ALL = 3'd4;
  localparam logic [FUNC_W-1:0] FN_INV_ALL = 3'd5;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd6;

  typedef struct packed {
    logic [POS_W-1:0]  disp_width;
    logic [POS_W-1:0]  disp_height;
    logic [GREY_W-1:0] grey_level;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/nfb_regs.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module nfb_regs
  import nfb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_DISP_WIDTH:  cfg_nxt.disp_width  = pwdata[POS_W-1:0];
        REG_DISP_HEIGHT: cfg_nxt.disp_height = pwdata[POS_W-1:0];
        REG_GREY_LEVEL:  cfg_nxt.grey_level  = pwdata[GREY_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DISP_WIDTH:  prdata = {{(PDATA_W-POS_W){1'b0}}, cfg_r.disp_width};
      REG_DISP_HEIGHT: prdata = {{(PDATA_W-POS_W){1'b0}}, cfg_r.disp_height};
      REG_GREY_LEVEL:  prdata = {{(PDATA_W-GREY_W){1'b0}}, cfg_r.grey_level};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.disp_width  <= DISP_WIDTH_RST;
      cfg_r.disp_height <= DISP_HEIGHT_RST;
      cfg_r.grey_level  <= GREY_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/nfb_store.sv
// Single-port pixel store with a registered read port.
`default_nettype none

module nfb_store
  import nfb_pkg::*;
#(
  parameter int DEPTH = STORE_ROWS_DEF * STORE_BYTES_PER_ROW_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              re,
  input  wire logic              we,
  input  wire logic [AW-1:0]     addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> design/nfb_ctrl.sv
// Command decoder and read-modify-write sequencer for the pixel store.
`default_nettype none

module nfb_ctrl
  import nfb_pkg::*;
#(
  parameter int STORE_ROWS          = STORE_ROWS_DEF,
  parameter int STORE_BYTES_PER_ROW = STORE_BYTES_PER_ROW_DEF,
  parameter int DEPTH               = STORE_ROWS * STORE_BYTES_PER_ROW,
  parameter int AW                  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [POS_W-1:0]  in_pos_x,
  input  wire logic [POS_W-1:0]  in_pos_y,
  input  wire logic [POS_W-1:0]  in_rect_width,
  input  wire logic [POS_W-1:0]  in_rect_height,
  input  wire logic [DATA_W-1:0] in_src_byte,
  output logic                   out_strobe,
  output logic                   out_accepted,
  output logic      [DATA_W-1:0] out_read_data,
  output logic                   mem_re,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_addr,
  output logic      [DATA_W-1:0] mem_wdata,
  input  wire logic [DATA_W-1:0] mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  localparam logic [POS_W:0] EW_MAX    = (POS_W+1)'(2 * STORE_BYTES_PER_ROW);
  localparam logic [POS_W:0] EH_MAX    = (POS_W+1)'(STORE_ROWS);
  localparam logic [POS_W:0] COLS_LIM  = (POS_W+1)'(STORE_BYTES_PER_ROW);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);

  logic [1:0]        state_r,  state_nxt;
  logic              init_r,   init_nxt;
  logic [FUNC_W-1:0] op_r,     op_nxt;
  logic [AW-1:0]     lin_r,    lin_nxt;
  logic [COL_W-1:0]  col_r,    col_nxt;
  logic [COL_W-1:0]  cfirst_r, cfirst_nxt;
  logic [COL_W-1:0]  clast_r,  clast_nxt;
  logic [ROW_W-1:0]  row_r,    row_nxt;
  logic [ROW_W-1:0]  y0_r,     y0_nxt;
  logic [ROW_W-1:0]  ylast_r,  ylast_nxt;
  logic              x0_r,     x0_nxt;
  logic              le_r,     le_nxt;
  logic [DATA_W-1:0] src_r,    src_nxt;
  logic              strobe_r, strobe_nxt;
  logic              acc_r,    acc_nxt;
  logic [DATA_W-1:0] data_r,   data_nxt;

  // Clipping arithmetic on the incoming command.
  logic [POS_W:0]    ew, eh, x9, y9, xw, yh, xe9, ye9, y7, yb9;
  logic              org_ok, rd_ok;

  // Byte modify datapath.
  logic              hi_en, lo_en, sweep, walk_done;
  logic [2:0]        bit_k;
  logic [GREY_W-1:0] nv;
  logic [DATA_W-1:0] new_byte;
  logic [AW-1:0]     rect_addr;

  assign busy          = (state_r != S_IDLE);
  assign out_strobe    = strobe_r;
  assign out_accepted  = acc_r;
  assign out_read_data = data_r;

  always_comb begin
    ew  = ({1'b0, cfg.disp_width}  < EW_MAX) ? {1'b0, cfg.disp_width}  : EW_MAX;
    eh  = ({1'b0, cfg.disp_height} < EH_MAX) ? {1'b0, cfg.disp_height} : EH_MAX;
    x9  = {1'b0, in_pos_x};
    y9  = {1'b0, in_pos_y};
    xw  = x9 + {1'b0, in_rect_width};
    yh  = y9 + {1'b0, in_rect_height};
    xe9 = (xw > ew) ? (ew - 9'd1) : (xw - 9'd1);
    ye9 = (yh > eh) ? (eh - 9'd1) : (yh - 9'd1);
    y7  = y9 + 9'd7;
    yb9 = (ye9 < y7) ? ye9 : y7;
    org_ok = (x9 < ew) && (y9 < eh);
    rd_ok  = (x9 < COLS_LIM) && (y9 < EH_MAX);
  end

  assign sweep     = (op_r == FN_INV_ALL);
  assign rect_addr = AW'(32'(row_r) * STORE_BYTES_PER_ROW + 32'(col_r));
  assign bit_k     = 3'(row_r - y0_r);

  always_comb begin
    if (sweep) begin
      hi_en = 1'b1;
      lo_en = 1'b1;
    end else begin
      hi_en = !((col_r == cfirst_r) && x0_r);
      lo_en = !((col_r == clast_r) && le_r);
    end
    case (op_r)
      FN_SET:  nv = cfg.grey_level;
      FN_BMP:  nv = src_r[bit_k] ? cfg.grey_level : '0;
      default: nv = '0;
    endcase
    case (op_r)
      FN_INV, FN_INV_ALL: begin
        new_byte = mem_rdata ^ {{GREY_W{hi_en}}, {GREY_W{lo_en}}};
      end
      FN_CLR: begin
        new_byte = mem_rdata & ~{{GREY_W{hi_en}}, {GREY_W{lo_en}}};
      end
      default: begin
        new_byte = {hi_en ? nv : mem_rdata[7:4], lo_en ? nv : mem_rdata[3:0]};
      end
    endcase
    if (sweep) begin
      walk_done = (lin_r == LAST_ADDR);
    end else begin
      walk_done = (col_r == clast_r) && (row_r == ylast_r);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    init_nxt   = init_r;
    op_nxt     = op_r;
    lin_nxt    = lin_r;
    col_nxt    = col_r;
    cfirst_nxt = cfirst_r;
    clast_nxt  = clast_r;
    row_nxt    = row_r;
    y0_nxt     = y0_r;
    ylast_nxt  = ylast_r;
    x0_nxt     = x0_r;
    le_nxt     = le_r;
    src_nxt    = src_r;
    strobe_nxt = 1'b0;
    acc_nxt    = acc_r;
    data_nxt   = data_r;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = (state_r == S_CLR || sweep) ? lin_r : rect_addr;
    mem_wdata  = new_byte;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_func;
          src_nxt    = in_src_byte;
          lin_nxt    = '0;
          data_nxt   = '0;
          row_nxt    = in_pos_y;
          y0_nxt     = in_pos_y;
          ylast_nxt  = in_pos_y;
          x0_nxt     = in_pos_x[0];
          le_nxt     = !in_pos_x[0];
          col_nxt    = in_pos_x[POS_W-1:1];
          cfirst_nxt = in_pos_x[POS_W-1:1];
          clast_nxt  = in_pos_x[POS_W-1:1];
          case (in_func)
            FN_SET, FN_CLR, FN_INV, FN_BMP: begin
              if (!org_ok) begin
                strobe_nxt = 1'b1;
                acc_nxt    = 1'b0;
              end else if ((in_func != FN_SET) && (in_rect_height == '0 ||
                           (in_func != FN_BMP && in_rect_width == '0))) begin
                // An empty area changes nothing.
                strobe_nxt = 1'b1;
                acc_nxt    = 1'b1;
              end else begin
                state_nxt = S_RD;
                if (in_func == FN_CLR || in_func == FN_INV) begin
                  clast_nxt = xe9[POS_W-1:1];
                  le_nxt    = !xe9[0];
                  ylast_nxt = ye9[ROW_W-1:0];
                end else if (in_func == FN_BMP) begin
                  ylast_nxt = yb9[ROW_W-1:0];
                end
              end
            end
            FN_CLR_ALL: begin
              state_nxt = S_CLR;
            end
            FN_INV_ALL: begin
              state_nxt = S_RD;
            end
            FN_READ: begin
              if (rd_ok) begin
                state_nxt  = S_RD;
                col_nxt    = in_pos_x[COL_W-1:0];
                cfirst_nxt = in_pos_x[COL_W-1:0];
                clast_nxt  = in_pos_x[COL_W-1:0];
              end else begin
                strobe_nxt = 1'b1;
                acc_nxt    = 1'b0;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
              acc_nxt    = 1'b0;
            end
          endcase
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        mem_we = (op_r != FN_READ);
        if (op_r == FN_READ) begin
          data_nxt = mem_rdata;
        end
        if (walk_done) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          acc_nxt    = 1'b1;
        end else begin
          state_nxt = S_RD;
          lin_nxt   = lin_r + AW'(1);
          if (col_r == clast_r) begin
            col_nxt = cfirst_r;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        lin_nxt   = lin_r + AW'(1);
        if (lin_r == LAST_ADDR) begin
          state_nxt  = S_IDLE;
          init_nxt   = 1'b0;
          strobe_nxt = !init_r;
          acc_nxt    = 1'b1;
          data_nxt   = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      init_r   <= 1'b1;
      op_r     <= FN_CLR_ALL;
      lin_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      init_r   <= init_nxt;
      op_r     <= op_nxt;
      lin_r    <= lin_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    cfirst_r <= cfirst_nxt;
    clast_r  <= clast_nxt;
    row_r    <= row_nxt;
    y0_r     <= y0_nxt;
    ylast_r  <= ylast_nxt;
    x0_r     <= x0_nxt;
    le_r     <= le_nxt;
    src_r    <= src_nxt;
    acc_r    <= acc_nxt;
    data_r   <= data_nxt;
  end

endmodule

`default_nettype wire

>>> design/nibble_framebuffer_raster_ops_top.sv
// Top level of the packed 4-bit grey framebuffer with raster commands.
`default_nettype none

// The block holds a display store of 4-bit grey pixels, two to a byte, with
// the even column in the high nibble. A command is taken at a rising edge
// where start is high and busy is low; each command yields exactly one result
// beat on out_accepted and out_read_data, marked by out_strobe for a single
// cycle. The receiver cannot stall, so results are never held back.
//
// Every store byte that a drawing command or invert all touches is handled by
// one read-modify-write through the single memory port: a read and then a
// write. Read byte reads its byte and writes nothing. Set pixel and read byte
// each visit one byte, a rectangle every touched byte, and a bitmap byte one
// byte per painted row. Clear all writes one byte a cycle with no reads;
// invert all needs a read and a write per byte. Rejected commands, unused
// codes and empty areas report in the cycle after acceptance. busy is low in
// the result beat cycle, so the next command can be taken in that cycle, and
// rejected ones can follow one every cycle.
//
// After reset the sequencer runs a clearing pass over all DEPTH bytes of the
// store (8192 bytes at the default size) with busy high and no result beat.
// Configuration writes are taken at any time, but are meant to come only while
// the block is idle.

module nibble_framebuffer_raster_ops_top
  import nfb_pkg::*;
#(
  parameter int STORE_ROWS          = STORE_ROWS_DEF,
  parameter int STORE_BYTES_PER_ROW = STORE_BYTES_PER_ROW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Command channel.
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [POS_W-1:0]   in_pos_x,
  input  wire logic [POS_W-1:0]   in_pos_y,
  input  wire logic [POS_W-1:0]   in_rect_width,
  input  wire logic [POS_W-1:0]   in_rect_height,
  input  wire logic [DATA_W-1:0]  in_src_byte,
  // Result channel.
  output logic                    out_strobe,
  output logic                    out_accepted,
  output logic      [DATA_W-1:0]  out_read_data,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int DEPTH = STORE_ROWS * STORE_BYTES_PER_ROW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t              cfg;
  logic              mem_re;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  nfb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The sequencer owns the only memory port; no two accesses ever overlap.
  nfb_ctrl #(
    .STORE_ROWS          (STORE_ROWS),
    .STORE_BYTES_PER_ROW (STORE_BYTES_PER_ROW),
    .DEPTH               (DEPTH),
    .AW                  (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_src_byte    (in_src_byte),
    .out_strobe     (out_strobe),
    .out_accepted   (out_accepted),
    .out_read_data  (out_read_data),
    .mem_re         (mem_re),
    .mem_we         (mem_we),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata)
  );

  nfb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .re    (mem_re),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> tb/sv/nibble_framebuffer_raster_ops_top_tb.sv
// Self-checking testbench for the packed 4-bit grey framebuffer raster block.
`timescale 1ns / 100ps

// The bench keeps its own copy of the pixel store and of the three
// configuration registers. Each accepted command beat is run through that
// shadow copy at the edge where the block takes it, and the predicted result
// is queued. A separate process compares every result beat with the oldest
// prediction. Stimulus is a short directed part followed by random traffic in
// several configuration phases. Configuration is only written while nothing
// is in flight.

module nibble_framebuffer_raster_ops_top_tb;
  import nfb_pkg::*;

  // The one command code that the block does not define.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  localparam int BYTES_PER_ROW = STORE_BYTES_PER_ROW_DEF;
  localparam int ROWS          = STORE_ROWS_DEF;
  localparam int ITEMS_PER_PHASE = 250;

  // The slowest single command, invert all, reads and writes all 8192 bytes
  // with no beat on either side, and the clearing pass after reset clears them
  // once more. Anything well past that with no beat at all means a hung block.
  localparam int STALL_LIMIT = 100000;

  typedef enum logic [1:0] {
    NIB_WRITE,
    NIB_CLEAR,
    NIB_FLIP
  } nibble_op_t;

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] read_data;
  } raster_result_t;

  logic clk;
  logic rst_n;

  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  in_func;
  logic [POS_W-1:0]   in_pos_x;
  logic [POS_W-1:0]   in_pos_y;
  logic [POS_W-1:0]   in_rect_width;
  logic [POS_W-1:0]   in_rect_height;
  logic [DATA_W-1:0]  in_src_byte;
  logic               out_strobe;
  logic               out_accepted;
  logic [DATA_W-1:0]  out_read_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Shadow copy of the display store and of the configuration registers.
  logic [DATA_W-1:0] shadow_pixels [0:ROWS*BYTES_PER_ROW-1];
  int                shadow_width;
  int                shadow_height;
  logic [GREY_W-1:0] shadow_grey;

  // Predicted result beats, oldest first.
  raster_result_t pending_results[$];

  int mismatch_count;
  int idle_cycles;
  // While nonzero, the sender issues beats back to back with no gaps.
  int burst_left;

  nibble_framebuffer_raster_ops_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_src_byte    (in_src_byte),
    .out_strobe     (out_strobe),
    .out_accepted   (out_accepted),
    .out_read_data  (out_read_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The logical size saturates at the physical store size for every check.
  function automatic int eff_width();
    return (shadow_width < 2 * BYTES_PER_ROW) ? shadow_width : 2 * BYTES_PER_ROW;
  endfunction

  function automatic int eff_height();
    return (shadow_height < ROWS) ? shadow_height : ROWS;
  endfunction

  // One nibble of the shadow store. The even column lives in the high nibble.
  // Pixels that fall outside the physical store are silently dropped.
  function automatic void touch_nibble(int x, int y, nibble_op_t op,
                                       logic [GREY_W-1:0] grey);
    int col;
    int idx;
    logic [DATA_W-1:0] b;
    col = x >> 1;
    if (col >= BYTES_PER_ROW || y >= ROWS) return;
    idx = y * BYTES_PER_ROW + col;
    b = shadow_pixels[idx];
    if ((x & 1) == 0) begin
      case (op)
        NIB_WRITE: b = {grey, b[3:0]};
        NIB_CLEAR: b = b & 8'h0F;
        default:   b = b ^ 8'hF0;
      endcase
    end else begin
      case (op)
        NIB_WRITE: b = {b[7:4], grey};
        NIB_CLEAR: b = b & 8'hF0;
        default:   b = b ^ 8'h0F;
      endcase
    end
    shadow_pixels[idx] = b;
  endfunction

  // Applies one command to the shadow store and returns the result beat
  // that the block must produce for it.
  function automatic raster_result_t apply_raster_cmd(
      logic [FUNC_W-1:0] func, int x, int y, int w, int h,
      logic [DATA_W-1:0] src);
    raster_result_t r;
    int ew;
    int eh;
    int rows;
    ew = eff_width();
    eh = eff_height();
    r = '0;
    case (func)
      FN_SET, FN_CLR, FN_INV, FN_BMP: begin
        // The origin must lie inside the logical area; the extent is clipped.
        if (x < ew && y < eh) begin
          r.accepted = 1'b1;
          if (x + w > ew) w = ew - x;
          if (y + h > eh) h = eh - y;
          case (func)
            FN_SET: touch_nibble(x, y, NIB_WRITE, shadow_grey);
            FN_CLR, FN_INV: begin
              for (int j = 0; j < h; j++)
                for (int i = 0; i < w; i++)
                  touch_nibble(x + i, y + j, (func == FN_CLR) ? NIB_CLEAR : NIB_FLIP,
                               4'h0);
            end
            default: begin
              // A bitmap byte paints one column, bit 0 on top; width is unused.
              rows = (h < 8) ? h : 8;
              for (int k = 0; k < rows; k++)
                touch_nibble(x, y + k, NIB_WRITE, src[k] ? shadow_grey : 4'h0);
            end
          endcase
        end
      end
      FN_CLR_ALL: begin
        foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
        r.accepted = 1'b1;
      end
      FN_INV_ALL: begin
        foreach (shadow_pixels[i]) shadow_pixels[i] = ~shadow_pixels[i];
        r.accepted = 1'b1;
      end
      FN_READ: begin
        // Reads address the physical store and ignore the logical size.
        if (x < BYTES_PER_ROW && y < ROWS) begin
          r.accepted  = 1'b1;
          r.read_data = shadow_pixels[y * BYTES_PER_ROW + x];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sends one command beat and waits for the edge that takes it. After that
  // the sender may idle for a random gap. With no gap, start simply stays
  // high and the next call puts new fields on the same cycle.
  task automatic issue_cmd(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [POS_W-1:0] w,
                           input logic [POS_W-1:0] h, input logic [DATA_W-1:0] src);
    int gap;
    int roll;
    start          <= 1'b1;
    in_func        <= func;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_rect_width  <= w;
    in_rect_height <= h;
    in_src_byte    <= src;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_raster_cmd(func, int'(x), int'(y), int'(w), int'(h),
                                               src));

    // Mostly short gaps, a few long ones, and now and then a gapless burst.
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        burst_left = $urandom_range(20, 60);
        gap = 0;
      end else if (roll < 50) begin
        gap = 0;
      end else if (roll < 90) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 60);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every predicted result has come back and the
  // block has dropped busy, then lets a few more cycles pass.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write: a setup cycle, then an access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DISP_WIDTH:  shadow_width  = int'(value[POS_W-1:0]);
      REG_DISP_HEIGHT: shadow_height = int'(value[POS_W-1:0]);
      REG_GREY_LEVEL:  shadow_grey   = value[GREY_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Writes all three registers while the block is idle. The unused upper
  // bits carry junk, since the block must mask them off.
  task automatic set_config(input int width, input int height, input int grey);
    wait_idle();
    write_reg(REG_DISP_WIDTH, ($urandom & 32'hFFFF_FF00) | (width & 'hFF));
    write_reg(REG_DISP_HEIGHT, ($urandom & 32'hFFFF_FF00) | (height & 'hFF));
    write_reg(REG_GREY_LEVEL, ($urandom & 32'hFFFF_FFF0) | (grey & 'hF));
  endtask

  // Single pixels at the corners of the default area, read back, and
  // origins just past the right and bottom edges.
  task automatic test_single_pixel_and_read();
    issue_cmd(FN_SET, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_SET, 8'd1, 8'd0, 8'd255, 8'd255, 8'hFF);
    issue_cmd(FN_SET, 8'd127, 8'd95, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_READ, 8'd63, 8'd95, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_SET, 8'd128, 8'd0, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_SET, 8'd0, 8'd96, 8'd0, 8'd0, 8'h00);
  endtask

  // An empty rectangle, a rectangle clipped at the bottom right, a bitmap column
  // clipped at the bottom, and a bitmap column cut short by its row count.
  task automatic test_rect_and_bitmap_clipping();
    issue_cmd(FN_CLR, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_INV, 8'd120, 8'd90, 8'd255, 8'd255, 8'h00);
    issue_cmd(FN_BMP, 8'd5, 8'd92, 8'd255, 8'd255, 8'hA5);
    issue_cmd(FN_BMP, 8'd6, 8'd0, 8'd0, 8'd3, 8'hFF);
    issue_cmd(FN_READ, 8'd61, 8'd93, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_READ, 8'd2, 8'd0, 8'd0, 8'd0, 8'h00);
  endtask

  // Whole-store inversion and clearing, reads past the physical store, and
  // the one undefined command code.
  task automatic test_whole_store_ops();
    issue_cmd(FN_INV_ALL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_READ, 8'd64, 8'd0, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_READ, 8'd0, 8'd128, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_READ, 8'd255, 8'd255, 8'd255, 8'd255, 8'hFF);
    issue_cmd(FN_UNUSED, 8'd1, 8'd1, 8'd1, 8'd1, 8'h01);
    issue_cmd(FN_READ, 8'd3, 8'd1, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_CLR_ALL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_READ, 8'd60, 8'd93, 8'd0, 8'd0, 8'h00);
  endtask

  // A zero logical width rejects every drawing command but not reads.
  // A logical size past the store saturates at the store size.
  task automatic test_config_extremes();
    set_config(0, 96, 15);
    issue_cmd(FN_SET, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
    set_config(255, 255, 0);
    issue_cmd(FN_SET, 8'd127, 8'd127, 8'd0, 8'd0, 8'h00);
    issue_cmd(FN_READ, 8'd63, 8'd127, 8'd0, 8'd0, 8'h00);
  endtask

  // Random traffic in phases, each with its own configuration. Most origins
  // fall inside the logical area so that drawing commands really draw, and
  // reads sweep the store to see their effects. A few beats are pure noise,
  // large rectangles or whole-store commands.
  task automatic test_random_traffic();
    int pick;
    int ew;
    int eh;
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  w;
    logic [POS_W-1:0]  h;
    logic [DATA_W-1:0] src;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(128, 96, 15);
        1: set_config(255, 255, 7);
        2: set_config(1, 1, 0);
        3: set_config(128, 128, 3);
        default: set_config($urandom_range(1, 255), $urandom_range(1, 255),
                            $urandom_range(0, 15));
      endcase
      ew = eff_width();
      eh = eff_height();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        x    = POS_W'($urandom_range(0, ew - 1));
        y    = POS_W'($urandom_range(0, eh - 1));
        w    = POS_W'($urandom_range(0, 8));
        h    = POS_W'($urandom_range(0, 8));
        src  = DATA_W'($urandom);
        if (pick < 25) begin
          f = FN_SET;
        end else if (pick < 45) begin
          f = FN_READ;
          x = POS_W'($urandom_range(0, BYTES_PER_ROW - 1));
          y = POS_W'($urandom_range(0, ROWS - 1));
          if ($urandom_range(0, 9) == 0) begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
          end
        end else if (pick < 60) begin
          f = FN_CLR;
        end else if (pick < 75) begin
          f = FN_INV;
        end else if (pick < 92) begin
          f = FN_BMP;
          w = POS_W'($urandom);
          h = POS_W'($urandom_range(0, 12));
        end else if (pick < 96) begin
          // Noise: any code, any coordinates, any sizes.
          f = FUNC_W'($urandom_range(0, 7));
          x = POS_W'($urandom);
          y = POS_W'($urandom);
          w = POS_W'($urandom);
          h = POS_W'($urandom);
        end else if (pick < 98) begin
          f = (pick == 97) ? FN_INV : FN_CLR;
          w = POS_W'($urandom);
          h = POS_W'($urandom);
        end else begin
          f = (pick == 98) ? FN_CLR_ALL : FN_INV_ALL;
        end
        issue_cmd(f, x, y, w, h, src);
      end
    end
  endtask

  // Every result beat is matched against the oldest prediction. A beat with
  // nothing predicted is a failure of its own.
  always @(posedge clk) begin : check_results
    raster_result_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected: accepted %b read_data %02h",
                 $time, out_accepted, out_read_data);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_accepted !== want.accepted) begin
          $display("%0t: accepted expected %b actual %b", $time, want.accepted,
                   out_accepted);
          mismatch_count++;
        end
        if (out_read_data !== want.read_data) begin
          $display("%0t: read_data expected %02h actual %02h", $time, want.read_data,
                   out_read_data);
          mismatch_count++;
        end
      end
    end
  end

  // A cycle counts as progress when a command beat or a result beat moves.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("nibble_framebuffer_raster_ops_top: mismatch");
      $finish;
    end
  end

  initial begin
    // Every input is known from time zero.
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_func        <= FN_SET;
    in_pos_x       <= '0;
    in_pos_y       <= '0;
    in_rect_width  <= '0;
    in_rect_height <= '0;
    in_src_byte    <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    burst_left     = 0;

    // The shadow copy starts in the block's reset state.
    foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
    shadow_width  = int'(DISP_WIDTH_RST);
    shadow_height = int'(DISP_HEIGHT_RST);
    shadow_grey   = GREY_LEVEL_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its store after reset with busy high; the first
    // command simply waits for that to finish.
    test_single_pixel_and_read();
    test_rect_and_bitmap_clipping();
    test_whole_store_ops();
    test_config_extremes();
    test_random_traffic();

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("nibble_framebuffer_raster_ops_top: match");
    end else begin
      $display("nibble_framebuffer_raster_ops_top: mismatch");
    end
    $finish;
  end

endmodule

>>> nibble_framebuffer_raster_ops_top.f
design/nfb_pkg.sv
design/nfb_regs.sv
design/nfb_store.sv
design/nfb_ctrl.sv
design/nibble_framebuffer_raster_ops_top.sv
tb/sv/nibble_framebuffer_raster_ops_top_tb.sv
